@@ sv/assert_macros.svh @@
// Assertion macros for the checker file cdo_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define CDO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CDO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/cdo_pkg.sv @@
package cdo_pkg;

  localparam int BASE_YEAR     = 1900;
  localparam int YEAR_SPAN_DEF = 256;

  localparam int REQ_W   = 2;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int OFF_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int WD_W    = 3;
  localparam int YD_W    = 9;
  localparam int ERR_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_SUB  = 2'd1,
    REQ_DIFF = 2'd2
  } req_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 2'd0,
    ERR_DATE = 2'd1,
    ERR_SPAN = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_CLR  = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  // Control word from the sequencer to the shared accumulator.
  typedef struct packed {
    acc_op_e         op;
    logic            clr_stats;
    logic            wd_en;
    logic            yd_en;
    logic [WD_W-1:0] wd_add;
    logic [YD_W-1:0] yd_add;
  } acc_ctrl_t;

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [YD_W-1:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  // Since 8 is 1 modulo 7, the octal digits can be summed before one correction.
  function automatic logic [WD_W-1:0] mod7_small(input logic [DAY_W-1:0] v);
    logic [3:0] s;
    s = {2'b00, v[4:3]} + {1'b0, v[2:0]};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[WD_W-1:0];
  endfunction

endpackage

@@ sv/cdo_if.sv @@
interface cdo_req_if;
  logic                          valid;
  logic                          ready;
  logic [cdo_pkg::REQ_W-1:0]     req_type;
  logic [cdo_pkg::DAY_W-1:0]     day_a;
  logic [cdo_pkg::MONTH_W-1:0]   month_a;
  logic [cdo_pkg::YEAR_W-1:0]    year_a;
  logic [cdo_pkg::DAY_W-1:0]     day_b;
  logic [cdo_pkg::MONTH_W-1:0]   month_b;
  logic [cdo_pkg::YEAR_W-1:0]    year_b;
  logic [cdo_pkg::OFF_W-1:0]     offset_days;

  modport source (output valid, req_type, day_a, month_a, year_a, day_b, month_b,
                  year_b, offset_days, input ready);
  modport sink (input valid, req_type, day_a, month_a, year_a, day_b, month_b,
                year_b, offset_days, output ready);
endinterface

interface cdo_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [cdo_pkg::DAY_W-1:0]          res_day;
  logic [cdo_pkg::MONTH_W-1:0]        res_month;
  logic [cdo_pkg::YEAR_W-1:0]         res_year;
  logic signed [cdo_pkg::DIFF_W-1:0]  day_difference;
  logic [cdo_pkg::WD_W-1:0]           week_day;
  logic [cdo_pkg::YD_W-1:0]           year_day;
  logic [cdo_pkg::ERR_W-1:0]          error;

  modport source (output valid, res_day, res_month, res_year, day_difference, week_day,
                  year_day, error, input ready);
  modport sink (input valid, res_day, res_month, res_year, day_difference, week_day,
                year_day, error, output ready);
endinterface

@@ sv/cdo_year_ctr.sv @@
module cdo_year_ctr (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic                         step_i,
  output logic [cdo_pkg::YEAR_W-1:0]   year_o,
  output logic                         leap_o
);

  localparam logic [cdo_pkg::YEAR_W-1:0] YearInit = cdo_pkg::YEAR_W'(cdo_pkg::BASE_YEAR);
  localparam logic [1:0] C4Init   = 2'(cdo_pkg::BASE_YEAR % 4);
  localparam logic [6:0] C100Init = 7'(cdo_pkg::BASE_YEAR % 100);
  localparam logic [8:0] C400Init = 9'(cdo_pkg::BASE_YEAR % 400);

  logic [cdo_pkg::YEAR_W-1:0] year_q, year_d;
  logic [1:0] c4_q, c4_d;
  logic [6:0] c100_q, c100_d;
  logic [8:0] c400_q, c400_d;

  // Residues of the year modulo 4, 100 and 400 run alongside the year itself.
  always_comb begin
    year_d = year_q;
    c4_d   = c4_q;
    c100_d = c100_q;
    c400_d = c400_q;
    if (clr_i) begin
      year_d = YearInit;
      c4_d   = C4Init;
      c100_d = C100Init;
      c400_d = C400Init;
    end else if (step_i) begin
      year_d = year_q + 1'b1;
      c4_d   = c4_q + 1'b1;
      c100_d = (c100_q == 7'd99) ? 7'd0 : c100_q + 1'b1;
      c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= YearInit;
      c4_q   <= C4Init;
      c100_q <= C100Init;
      c400_q <= C400Init;
    end else begin
      year_q <= year_d;
      c4_q   <= c4_d;
      c100_q <= c100_d;
      c400_q <= c400_d;
    end
  end

  assign year_o = year_q;
  assign leap_o = (c4_q == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));

endmodule

@@ sv/cdo_accum.sv @@
module cdo_accum #(
  parameter int AccW = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdo_pkg::acc_ctrl_t            ctrl_i,
  input  logic signed [AccW-1:0]        operand_i,
  output logic signed [AccW-1:0]        acc_o,
  output logic [cdo_pkg::WD_W-1:0]      wd_o,
  output logic [cdo_pkg::YD_W-1:0]      yd_o
);

  logic signed [AccW-1:0]       acc_q, acc_d;
  logic [cdo_pkg::WD_W-1:0]     wd_q, wd_d;
  logic [cdo_pkg::YD_W-1:0]     yd_q, yd_d;
  logic [cdo_pkg::WD_W:0]       wd_sum;

  always_comb begin
    unique case (ctrl_i.op)
      cdo_pkg::ACC_HOLD: acc_d = acc_q;
      cdo_pkg::ACC_CLR:  acc_d = '0;
      cdo_pkg::ACC_ADD:  acc_d = acc_q + operand_i;
      cdo_pkg::ACC_SUB:  acc_d = acc_q - operand_i;
      default:           acc_d = acc_q;
    endcase
  end

  // The weekday is kept as the running day count modulo 7.
  always_comb begin
    wd_sum = {1'b0, wd_q} + {1'b0, ctrl_i.wd_add};
    if (wd_sum >= 4'd7) begin
      wd_sum = wd_sum - 4'd7;
    end
    wd_d = wd_q;
    yd_d = yd_q;
    if (ctrl_i.clr_stats) begin
      wd_d = '0;
      yd_d = '0;
    end else begin
      if (ctrl_i.wd_en) begin
        wd_d = wd_sum[cdo_pkg::WD_W-1:0];
      end
      if (ctrl_i.yd_en) begin
        yd_d = yd_q + ctrl_i.yd_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      wd_q  <= '0;
      yd_q  <= '0;
    end else begin
      acc_q <= acc_d;
      wd_q  <= wd_d;
      yd_q  <= yd_d;
    end
  end

  assign acc_o = acc_q;
  assign wd_o  = wd_q;
  assign yd_o  = yd_q;

endmodule

@@ sv/calendar_date_offset_and_difference_top.sv @@
// Channel  Modport        Direction  Payload
// req_i    sink           in         req_type, day_a..year_a, day_b..year_b, offset_days
// rsp_o    source         out        res_day, res_month, res_year, day_difference,
//                                    week_day, year_day, error
//
// One item at a time. A move walks the years past 1900 and the months of its date,
// adds the offset, and walks years and months again to find the result; a difference
// walks the years and months of both dates. All walks go through the single shared
// add/subtract accumulator. Reset is asynchronous and needs no clearing pass.
// req_i.ready is high only while the sequencer is idle; a finished result waits in
// the output register and does not hold up the next item, but the next result waits
// until that one is taken.
module calendar_date_offset_and_difference_top #(
  parameter int YEAR_SPAN = cdo_pkg::YEAR_SPAN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdo_req_if.sink    req_i,
  cdo_rsp_if.source  rsp_o
);

  localparam int LastYear = cdo_pkg::BASE_YEAR + YEAR_SPAN - 1;
  localparam int FirstPrev = cdo_pkg::BASE_YEAR - 1;
  localparam int LeapCnt = (LastYear / 4 - LastYear / 100 + LastYear / 400)
                         - (FirstPrev / 4 - FirstPrev / 100 + FirstPrev / 400);
  localparam int LastDay = 365 * YEAR_SPAN + LeapCnt;
  localparam int DnW = $clog2(LastDay + 1);
  localparam int AccW = ((DnW > cdo_pkg::OFF_W) ? DnW : cdo_pkg::OFF_W) + 2;
  localparam logic signed [AccW-1:0] LastDayS = AccW'(LastDay);
  localparam logic signed [AccW-1:0] OneS = AccW'(1);
  localparam logic [cdo_pkg::YEAR_W-1:0] YearFirst = cdo_pkg::YEAR_W'(cdo_pkg::BASE_YEAR);
  localparam logic [cdo_pkg::YEAR_W-1:0] YearEnd =
    cdo_pkg::YEAR_W'(cdo_pkg::BASE_YEAR + YEAR_SPAN);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_YEARS  = 9'b000000100,
    S_MONTHS = 9'b000001000,
    S_OFFSET = 9'b000010000,
    S_RANGE  = 9'b000100000,
    S_DYEAR  = 9'b001000000,
    S_DMONTH = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [cdo_pkg::REQ_W-1:0]   req_q;
  logic [cdo_pkg::DAY_W-1:0]   da_q, db_q;
  logic [cdo_pkg::MONTH_W-1:0] ma_q, mb_q;
  logic [cdo_pkg::YEAR_W-1:0]  ya_q, yb_q;
  logic [cdo_pkg::OFF_W-1:0]   off_q;

  logic                        sel_b_q, sel_b_d;
  logic [cdo_pkg::MONTH_W-1:0] mi_q, mi_d;
  logic [cdo_pkg::ERR_W-1:0]   err_q, err_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;

  logic [cdo_pkg::DAY_W-1:0]          out_day_q;
  logic [cdo_pkg::MONTH_W-1:0]        out_month_q;
  logic [cdo_pkg::YEAR_W-1:0]         out_year_q;
  logic signed [cdo_pkg::DIFF_W-1:0]  out_diff_q;
  logic [cdo_pkg::WD_W-1:0]           out_wd_q;
  logic [cdo_pkg::YD_W-1:0]           out_yd_q;
  logic [cdo_pkg::ERR_W-1:0]          out_err_q;

  logic                        in_fire;
  logic [cdo_pkg::DAY_W-1:0]   cur_d;
  logic [cdo_pkg::MONTH_W-1:0] cur_m;
  logic [cdo_pkg::YEAR_W-1:0]  cur_y;
  logic                        ok_a, ok_b, req_ok;

  cdo_pkg::acc_ctrl_t          ctrl;
  logic signed [AccW-1:0]      operand;
  logic signed [AccW-1:0]      acc;
  logic [cdo_pkg::WD_W-1:0]    wd;
  logic [cdo_pkg::YD_W-1:0]    yd;
  logic                        ystep, yclr;
  logic [cdo_pkg::YEAR_W-1:0]  cy;
  logic                        leap;
  logic [cdo_pkg::YD_W-1:0]    yl;
  logic [cdo_pkg::DAY_W-1:0]   ml, cur_ml;

  cdo_year_ctr u_year_ctr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (yclr),
    .step_i (ystep),
    .year_o (cy),
    .leap_o (leap)
  );

  cdo_accum #(
    .AccW (AccW)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .operand_i (operand),
    .acc_o     (acc),
    .wd_o      (wd),
    .yd_o      (yd)
  );

  assign in_fire     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign cur_d = sel_b_q ? db_q : da_q;
  assign cur_m = sel_b_q ? mb_q : ma_q;
  assign cur_y = sel_b_q ? yb_q : ya_q;

  // Coarse checks; the day against the month length waits for the leap flag.
  assign ok_a = (ya_q >= YearFirst) && (ya_q < YearEnd) && (ma_q >= 4'd1) &&
                (ma_q <= 4'd12) && (da_q != '0);
  assign ok_b = (yb_q >= YearFirst) && (yb_q < YearEnd) && (mb_q >= 4'd1) &&
                (mb_q <= 4'd12) && (db_q != '0);

  always_comb begin
    case (req_q)
      cdo_pkg::REQ_ADD, cdo_pkg::REQ_SUB: req_ok = ok_a;
      cdo_pkg::REQ_DIFF:                  req_ok = ok_a && ok_b;
      default:                            req_ok = 1'b0;
    endcase
  end

  assign yl     = cdo_pkg::year_len(leap);
  assign ml     = cdo_pkg::month_len(leap, mi_q);
  assign cur_ml = cdo_pkg::month_len(leap, cur_m);

  always_comb begin
    state_d  = state_q;
    sel_b_d  = sel_b_q;
    mi_d     = mi_q;
    err_d    = err_q;
    ystep    = 1'b0;
    yclr     = 1'b0;
    out_load = 1'b0;
    operand  = '0;
    ctrl     = '{op: cdo_pkg::ACC_HOLD, clr_stats: 1'b0, wd_en: 1'b0, yd_en: 1'b0,
                 wd_add: '0, yd_add: '0};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          err_d   = cdo_pkg::ERR_NONE;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!req_ok) begin
          err_d   = cdo_pkg::ERR_DATE;
          state_d = S_DONE;
        end else begin
          ctrl.op        = cdo_pkg::ACC_CLR;
          ctrl.clr_stats = 1'b1;
          yclr           = 1'b1;
          sel_b_d        = 1'b0;
          state_d        = S_YEARS;
        end
      end
      // Date b is walked with subtraction so the accumulator ends at a minus b.
      S_YEARS: begin
        if (cy != cur_y) begin
          ctrl.op     = sel_b_q ? cdo_pkg::ACC_SUB : cdo_pkg::ACC_ADD;
          operand     = AccW'(yl);
          ctrl.wd_en  = !sel_b_q;
          ctrl.wd_add = leap ? 3'd2 : 3'd1;
          ystep       = 1'b1;
        end else if (cur_d > cur_ml) begin
          err_d   = cdo_pkg::ERR_DATE;
          state_d = S_DONE;
        end else begin
          mi_d    = 4'd1;
          state_d = S_MONTHS;
        end
      end
      S_MONTHS: begin
        ctrl.op    = sel_b_q ? cdo_pkg::ACC_SUB : cdo_pkg::ACC_ADD;
        ctrl.wd_en = !sel_b_q;
        ctrl.yd_en = !sel_b_q;
        if (mi_q != cur_m) begin
          operand     = AccW'(ml);
          ctrl.wd_add = cdo_pkg::mod7_small(ml);
          ctrl.yd_add = cdo_pkg::YD_W'(ml);
          mi_d        = mi_q + 1'b1;
        end else begin
          operand     = AccW'(cur_d);
          ctrl.wd_add = cdo_pkg::mod7_small(cur_d);
          ctrl.yd_add = cdo_pkg::YD_W'(cur_d);
          if (req_q == cdo_pkg::REQ_DIFF) begin
            if (!sel_b_q) begin
              sel_b_d = 1'b1;
              yclr    = 1'b1;
              state_d = S_YEARS;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            state_d = S_OFFSET;
          end
        end
      end
      S_OFFSET: begin
        ctrl.op = (req_q == cdo_pkg::REQ_SUB) ? cdo_pkg::ACC_SUB : cdo_pkg::ACC_ADD;
        operand = AccW'(off_q);
        state_d = S_RANGE;
      end
      S_RANGE: begin
        if ((acc < OneS) || (acc > LastDayS)) begin
          err_d   = cdo_pkg::ERR_SPAN;
          state_d = S_DONE;
        end else begin
          ctrl.clr_stats = 1'b1;
          yclr           = 1'b1;
          state_d        = S_DYEAR;
        end
      end
      S_DYEAR: begin
        operand = AccW'(yl);
        if (acc > operand) begin
          ctrl.op     = cdo_pkg::ACC_SUB;
          ctrl.wd_en  = 1'b1;
          ctrl.wd_add = leap ? 3'd2 : 3'd1;
          ystep       = 1'b1;
        end else begin
          mi_d    = 4'd1;
          state_d = S_DMONTH;
        end
      end
      S_DMONTH: begin
        operand    = AccW'(ml);
        ctrl.wd_en = 1'b1;
        ctrl.yd_en = 1'b1;
        if ((mi_q < 4'd12) && (acc > operand)) begin
          ctrl.op     = cdo_pkg::ACC_SUB;
          ctrl.wd_add = cdo_pkg::mod7_small(ml);
          ctrl.yd_add = cdo_pkg::YD_W'(ml);
          mi_d        = mi_q + 1'b1;
        end else begin
          // What is left in the accumulator is the day of the month.
          ctrl.wd_add = cdo_pkg::mod7_small(acc[cdo_pkg::DAY_W-1:0]);
          ctrl.yd_add = cdo_pkg::YD_W'(acc[cdo_pkg::DAY_W-1:0]);
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_b_q     <= 1'b0;
      mi_q        <= '0;
      err_q       <= cdo_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_b_q     <= sel_b_d;
      mi_q        <= mi_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_i.req_type;
      da_q  <= req_i.day_a;
      ma_q  <= req_i.month_a;
      ya_q  <= req_i.year_a;
      db_q  <= req_i.day_b;
      mb_q  <= req_i.month_b;
      yb_q  <= req_i.year_b;
      off_q <= req_i.offset_days;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_day_q   <= '0;
      out_month_q <= '0;
      out_year_q  <= '0;
      out_diff_q  <= '0;
      out_wd_q    <= '0;
      out_yd_q    <= '0;
      out_err_q   <= err_q;
      if (err_q == cdo_pkg::ERR_NONE) begin
        out_wd_q <= wd;
        out_yd_q <= yd;
        if (req_q == cdo_pkg::REQ_DIFF) begin
          out_diff_q <= acc[cdo_pkg::DIFF_W-1:0];
        end else begin
          out_day_q   <= acc[cdo_pkg::DAY_W-1:0];
          out_month_q <= mi_q;
          out_year_q  <= cy;
        end
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.res_day        = out_day_q;
  assign rsp_o.res_month      = out_month_q;
  assign rsp_o.res_year       = out_year_q;
  assign rsp_o.day_difference = out_diff_q;
  assign rsp_o.week_day       = out_wd_q;
  assign rsp_o.year_day       = out_yd_q;
  assign rsp_o.error          = out_err_q;

endmodule

@@ sv/cdo_checker.sv @@
`include "assert_macros.svh"

module cdo_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               req_valid_i,
  input logic                               req_ready_i,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic [cdo_pkg::DAY_W-1:0]          res_day_i,
  input logic [cdo_pkg::MONTH_W-1:0]        res_month_i,
  input logic [cdo_pkg::YEAR_W-1:0]         res_year_i,
  input logic signed [cdo_pkg::DIFF_W-1:0]  day_difference_i,
  input logic [cdo_pkg::WD_W-1:0]           week_day_i,
  input logic [cdo_pkg::YD_W-1:0]           year_day_i,
  input logic [cdo_pkg::ERR_W-1:0]          error_i
);

  logic err_set;

  assign err_set = (error_i != cdo_pkg::ERR_NONE);

  `CDO_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result dropped while stalled")

  `CDO_ASSERT(a_err_zero, rsp_valid_i && err_set |-> (res_day_i == '0) && (res_month_i == '0) && (res_year_i == '0) && (day_difference_i == '0) && (week_day_i == '0) && (year_day_i == '0), "error result carries nonzero fields")

  `CDO_ASSERT(a_wd_range, rsp_valid_i |-> (week_day_i < 3'd7) && (error_i != 2'd3), "weekday or error code out of range")

  `CDO_ASSERT(a_move_shape, rsp_valid_i && !err_set && (res_month_i != '0) |-> (day_difference_i == '0) && (res_day_i != '0) && (year_day_i != '0), "move result malformed")

  `CDO_ASSERT(a_not_instant, req_valid_i && req_ready_i |=> !req_ready_i, "item accepted without sequencing")

endmodule

bind calendar_date_offset_and_difference_top cdo_checker u_cdo_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .res_day_i        (rsp_o.res_day),
  .res_month_i      (rsp_o.res_month),
  .res_year_i       (rsp_o.res_year),
  .day_difference_i (rsp_o.day_difference),
  .week_day_i       (rsp_o.week_day),
  .year_day_i       (rsp_o.year_day),
  .error_i          (rsp_o.error)
);

@@ verif/cdo_date_checker.sv @@
module cdo_date_checker #(
  parameter int YEAR_SPAN = cdo_pkg::YEAR_SPAN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  cdo_req_if   req_i,
  cdo_rsp_if   rsp_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   results_o,
  output int   date_errors_o,
  output int   span_errors_o
);
  import cdo_pkg::*;

  typedef struct packed {
    logic [DAY_W-1:0]         day;
    logic [MONTH_W-1:0]       month;
    logic [YEAR_W-1:0]        year;
    logic signed [DIFF_W-1:0] day_difference;
    logic [WD_W-1:0]          week_day;
    logic [YD_W-1:0]          year_day;
    logic [ERR_W-1:0]         error;
  } date_result_t;

  date_result_t expected_results[$];

  initial begin
    mismatches_o  = 0;
    pending_o     = 0;
    results_o     = 0;
    date_errors_o = 0;
    span_errors_o = 0;
  end

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_year(input int y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int month_days(input int y, input int m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Per-month offsets of Sakamoto's weekday rule.
  function automatic int month_key(input int m);
    case (m)
      1, 5:    return 0;
      2:       return 3;
      3:       return 2;
      4:       return 5;
      6:       return 3;
      7:       return 5;
      8:       return 1;
      9, 12:   return 4;
      10:      return 6;
      default: return 2;
    endcase
  endfunction

  function automatic bit date_valid(input int d, input int m, input int y);
    if (y < BASE_YEAR || y >= BASE_YEAR + YEAR_SPAN) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_days(y, m));
  endfunction

  function automatic int day_in_year(input int d, input int m, input int y);
    int s;
    int i;
    s = d;
    for (i = 1; i < m; i++) s += month_days(y, i);
    return s;
  endfunction

  // Day 1 is 1 January of the base year.
  function automatic int day_serial(input int d, input int m, input int y);
    int s;
    int i;
    s = day_in_year(d, m, y);
    for (i = BASE_YEAR; i < y; i++) s += days_in_year(i);
    return s;
  endfunction

  function automatic int weekday_of(input int d, input int m, input int y);
    int yy;
    yy = (m < 3) ? y - 1 : y;
    return (yy + yy / 4 - yy / 100 + yy / 400 + month_key(m) + d) % 7;
  endfunction

  function automatic date_result_t predict_result(input int kind,
                                                  input int da, input int ma, input int ya,
                                                  input int db, input int mb, input int yb,
                                                  input int off);
    date_result_t r;
    int n;
    int t;
    int y;
    int m;
    r = '0;
    if ((kind != REQ_ADD && kind != REQ_SUB && kind != REQ_DIFF) || !date_valid(da, ma, ya)
        || (kind == REQ_DIFF && !date_valid(db, mb, yb))) begin
      r.error = ERR_DATE;
      return r;
    end
    if (kind == REQ_DIFF) begin
      r.day_difference = DIFF_W'(day_serial(da, ma, ya) - day_serial(db, mb, yb));
      r.week_day       = WD_W'(weekday_of(da, ma, ya));
      r.year_day       = YD_W'(day_in_year(da, ma, ya));
      return r;
    end
    n = day_serial(da, ma, ya);
    n = (kind == REQ_ADD) ? n + off : n - off;
    if (n < 1 || n > day_serial(31, 12, BASE_YEAR + YEAR_SPAN - 1)) begin
      r.error = ERR_SPAN;
      return r;
    end
    t = n;
    y = BASE_YEAR;
    while (t > days_in_year(y)) begin
      t -= days_in_year(y);
      y++;
    end
    m = 1;
    while (m < 12 && t > month_days(y, m)) begin
      t -= month_days(y, m);
      m++;
    end
    r.day      = DAY_W'(t);
    r.month    = MONTH_W'(m);
    r.year     = YEAR_W'(y);
    r.week_day = WD_W'(weekday_of(t, m, y));
    r.year_day = YD_W'(day_in_year(t, m, y));
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    date_result_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        expected_results.push_back(predict_result(req_i.req_type, req_i.day_a, req_i.month_a,
                                                  req_i.year_a, req_i.day_b, req_i.month_b,
                                                  req_i.year_b, req_i.offset_days));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        results_o++;
        if (expected_results.size() == 0) begin
          $error("result item arrived with no request outstanding");
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("res_day", want.day, rsp_i.res_day);
          check_field("res_month", want.month, rsp_i.res_month);
          check_field("res_year", want.year, rsp_i.res_year);
          check_field("day_difference", $signed(want.day_difference),
                      $signed(rsp_i.day_difference));
          check_field("week_day", want.week_day, rsp_i.week_day);
          check_field("year_day", want.year_day, rsp_i.year_day);
          check_field("error", want.error, rsp_i.error);
          if (want.error == ERR_DATE) date_errors_o++;
          if (want.error == ERR_SPAN) span_errors_o++;
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

@@ verif/calendar_date_offset_and_difference_top_test.sv @@
module calendar_date_offset_and_difference_top_test;
  import cdo_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;
  localparam int               LAST_YEAR    = BASE_YEAR + YEAR_SPAN_DEF - 1;
  localparam int               RANDOM_ITEMS = 1330;
  localparam int               MAX_OFFSET   = 93503;

  typedef struct packed {
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
  } cal_date_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    cal_date_t        a;
    cal_date_t        b;
    logic [OFF_W-1:0] offset;
  } date_req_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  bit        steady;
  int        mismatches;
  int        pending;
  int        results;
  int        date_errors;
  int        span_errors;
  date_req_t directed_reqs[$];

  cdo_req_if req_ch ();
  cdo_rsp_if rsp_ch ();

  calendar_date_offset_and_difference_top i_dut (
    .clk_i,
    .rst_ni,
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  cdo_date_checker i_checker (
    .clk_i,
    .rst_ni,
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .results_o     (results),
    .date_errors_o (date_errors),
    .span_errors_o (span_errors)
  );

  always #4 clk_i = ~clk_i;

  function automatic int month_end(input int y, input int m);
    if (m == 2) return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic date_req_t make_req(input logic [REQ_W-1:0] kind,
                                         input int da, input int ma, input int ya,
                                         input int db, input int mb, input int yb,
                                         input int off);
    date_req_t r;
    r.kind   = kind;
    r.a      = {DAY_W'(da), MONTH_W'(ma), YEAR_W'(ya)};
    r.b      = {DAY_W'(db), MONTH_W'(mb), YEAR_W'(yb)};
    r.offset = OFF_W'(off);
    return r;
  endfunction

  // A valid date, leaning toward the ends of the span and of the month.
  function automatic cal_date_t pick_date();
    cal_date_t c;
    int        y;
    int        m;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 10) y = BASE_YEAR + $urandom_range(3);
    else if (roll < 20) y = LAST_YEAR - $urandom_range(3);
    else y = BASE_YEAR + $urandom_range(YEAR_SPAN_DEF - 1);
    m = $urandom_range(12, 1);
    c.y = YEAR_W'(y);
    c.m = MONTH_W'(m);
    case ($urandom_range(3))
      0:       c.d = DAY_W'(1);
      1:       c.d = DAY_W'(month_end(y, m));
      default: c.d = DAY_W'($urandom_range(month_end(y, m), 1));
    endcase
    return c;
  endfunction

  // Mostly well-formed moves and differences; the rest is raw noise on every field.
  function automatic date_req_t random_req();
    date_req_t   r;
    logic [63:0] noise;
    int          roll;
    noise = {$urandom, $urandom};
    r     = noise[$bits(date_req_t)-1:0];
    roll  = $urandom_range(99);
    if (roll < 85) begin
      r.a = pick_date();
      if (roll < 60) begin
        r.kind = (roll < 30) ? REQ_ADD : REQ_SUB;
        case ($urandom_range(3))
          0: r.offset = OFF_W'($urandom_range(400));
          1: r.offset = OFF_W'($urandom_range(5000));
          2: r.offset = OFF_W'($urandom_range(MAX_OFFSET));
          default: ;
        endcase
      end else begin
        r.kind = REQ_DIFF;
        r.b    = pick_date();
      end
    end
    return r;
  endfunction

  task automatic send_req(input date_req_t r);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 34) gap++;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.kind;
    req_ch.day_a       <= r.a.d;
    req_ch.month_a     <= r.a.m;
    req_ch.year_a      <= r.a.y;
    req_ch.day_b       <= r.b.d;
    req_ch.month_b     <= r.b.m;
    req_ch.year_b      <= r.b.y;
    req_ch.offset_days <= r.offset;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  initial begin
    int i;
    steady             = 1'b0;
    rst_ni             <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_ADD;
    req_ch.day_a       <= '0;
    req_ch.month_a     <= '0;
    req_ch.year_a      <= '0;
    req_ch.day_b       <= '0;
    req_ch.month_b     <= '0;
    req_ch.year_b      <= '0;
    req_ch.offset_days <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Span edges, month and leap-day corners, and every kind of rejected date.
    directed_reqs.push_back(make_req(REQ_ADD, 1, 1, BASE_YEAR, 1, 1, BASE_YEAR, 0));
    directed_reqs.push_back(make_req(REQ_ADD, 31, 12, LAST_YEAR, 1, 1, BASE_YEAR, 0));
    directed_reqs.push_back(make_req(REQ_SUB, 1, 1, BASE_YEAR, 1, 1, BASE_YEAR, 1));
    directed_reqs.push_back(make_req(REQ_ADD, 31, 12, LAST_YEAR, 1, 1, BASE_YEAR, 1));
    directed_reqs.push_back(make_req(REQ_ADD, 1, 1, BASE_YEAR, 1, 1, BASE_YEAR, 93501));
    directed_reqs.push_back(make_req(REQ_ADD, 1, 1, BASE_YEAR, 1, 1, BASE_YEAR, 93502));
    directed_reqs.push_back(make_req(REQ_SUB, 31, 12, LAST_YEAR, 1, 1, BASE_YEAR, 93501));
    directed_reqs.push_back(make_req(REQ_ADD, 1, 1, BASE_YEAR, 0, 0, 0, (1 << OFF_W) - 1));
    directed_reqs.push_back(make_req(REQ_SUB, 31, 12, LAST_YEAR, 0, 0, 0, (1 << OFF_W) - 1));
    directed_reqs.push_back(make_req(REQ_DIFF, 1, 1, BASE_YEAR, 31, 12, LAST_YEAR, 0));
    directed_reqs.push_back(make_req(REQ_DIFF, 31, 12, LAST_YEAR, 1, 1, BASE_YEAR, 0));
    directed_reqs.push_back(make_req(REQ_DIFF, 15, 6, 2024, 15, 6, 2024, 0));
    directed_reqs.push_back(make_req(REQ_ADD, 29, 2, 2000, 1, 1, BASE_YEAR, 365));
    directed_reqs.push_back(make_req(REQ_ADD, 28, 2, BASE_YEAR, 1, 1, BASE_YEAR, 1));
    directed_reqs.push_back(make_req(REQ_ADD, 29, 2, BASE_YEAR, 1, 1, BASE_YEAR, 0));
    directed_reqs.push_back(make_req(REQ_ADD, 29, 2, 2100, 1, 1, BASE_YEAR, 0));
    directed_reqs.push_back(make_req(REQ_SUB, 0, 5, 2000, 1, 1, BASE_YEAR, 3));
    directed_reqs.push_back(make_req(REQ_ADD, 31, 4, 2001, 1, 1, BASE_YEAR, 3));
    directed_reqs.push_back(make_req(REQ_ADD, 1, 0, 2000, 1, 1, BASE_YEAR, 3));
    directed_reqs.push_back(make_req(REQ_ADD, 1, 13, 2000, 1, 1, BASE_YEAR, 3));
    directed_reqs.push_back(make_req(REQ_ADD, 1, 1, BASE_YEAR - 1, 1, 1, BASE_YEAR, 3));
    directed_reqs.push_back(make_req(REQ_ADD, 1, 1, LAST_YEAR + 1, 1, 1, BASE_YEAR, 3));
    directed_reqs.push_back(make_req(REQ_DIFF, 10, 10, 2010, 30, 2, 2004, 0));
    directed_reqs.push_back(make_req(REQ_UNUSED, 10, 10, 2010, 10, 10, 2010, 5));
    directed_reqs.push_back(make_req(REQ_ADD, 29, 2, 2004, 0, 15, 4095, 1000));

    foreach (directed_reqs[k]) send_req(directed_reqs[k]);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 400 && i < 650);
      send_req(random_req());
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    $display("Checked %0d results from %0d directed and %0d random requests.",
             results, directed_reqs.size(), RANDOM_ITEMS);
    $display("Of those, %0d were rejected as bad dates and %0d left the calendar span.",
             date_errors, span_errors);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/cdo_pkg.sv
sv/cdo_if.sv
sv/cdo_year_ctr.sv
sv/cdo_accum.sv
sv/calendar_date_offset_and_difference_top.sv
sv/cdo_checker.sv
verif/cdo_date_checker.sv
verif/calendar_date_offset_and_difference_top_test.sv
